// ===== design/wsvp_pkg.sv =====
// Shared types, widths and constants for the windowed signed-volume pressure block.
// No dependencies; used by wsvp_ring and windowed_signed_volume_pressure.
package wsvp_pkg;

    localparam int unsigned RING_DEPTH  = 256;
    localparam int unsigned RING_AW     = 8;
    localparam int unsigned WLEN_W      = 9;
    localparam int unsigned PRICE_W     = 32;
    localparam int unsigned VOL_W       = 32;
    localparam int unsigned SV_W        = VOL_W + 1;
    localparam int unsigned SUM_W       = 41;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned EMA_W       = 58;
    localparam int unsigned DLT_W       = EMA_W + 1;
    localparam int unsigned WORK_W      = 70;
    localparam int unsigned DIV5_W      = 64;
    localparam int unsigned DIGIT_W     = 16;
    localparam int unsigned DIV5_STEPS  = DIV5_W / DIGIT_W;
    localparam int unsigned RECIP_SHIFT = 21;
    localparam int unsigned Q_W         = 12;
    localparam int unsigned CNT_W       = 4;

    localparam logic [WLEN_W-1:0] DEFAULT_WINDOW = 9'd32;
    localparam logic [WLEN_W-1:0] MIN_WINDOW     = 9'd2;
    localparam logic [WLEN_W-1:0] MAX_WINDOW     = 9'd256;
    localparam logic [Q_W-1:0]    FULL_SCALE     = 12'd2560;
    // ceil(2^21 / 5): exact floor(x / 5) for x below 2^19
    localparam logic [18:0]       RECIP5         = 19'd419431;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SUM  = 8'b0000_0010,
        ST_TGT  = 8'b0000_0100,
        ST_DIV5 = 8'b0000_1000,
        ST_EMA  = 8'b0001_0000,
        ST_CMP  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] ptr;
        logic [WLEN_W-1:0]  win;
        logic [SV_W-1:0]    wr_data;
    } ring_req_t;

    function automatic logic [WLEN_W-1:0] eff_window(input logic [WLEN_W-1:0] w);
        logic [WLEN_W-1:0] e;
        e = w;
        if (w < MIN_WINDOW) begin
            e = DEFAULT_WINDOW;
        end else if (w > MAX_WINDOW) begin
            e = MAX_WINDOW;
        end
        return e;
    endfunction

endpackage

// ===== design/wsvp_ring.sv =====
// Ring of signed volumes: one write port at the write pointer, one registered
// read port at the entry leaving the window. Depends on wsvp_pkg.
module wsvp_ring (
    input  logic                       aclk,
    input  wsvp_pkg::ring_req_t        req,
    output logic [wsvp_pkg::SV_W-1:0]  old_vol
);

    logic [wsvp_pkg::SV_W-1:0]    mem [0:wsvp_pkg::RING_DEPTH-1];
    logic [wsvp_pkg::SV_W-1:0]    rd_data_reg;
    logic [wsvp_pkg::RING_AW-1:0] rd_addr;

    // oldest entry sits one window behind the pointer, modulo the ring
    assign rd_addr = req.ptr - req.win[wsvp_pkg::RING_AW-1:0];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.ptr] <= req.wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign old_vol = rd_data_reg;

endmodule

// ===== design/windowed_signed_volume_pressure.sv =====
// Windowed signed-volume pressure marker, top level. Depends on wsvp_pkg, wsvp_ring.
// Per item: a bar with no result (first two of a series) returns to IDLE after SUM;
// the seeding bar runs SUM, TGT, CMP, OUT; a steady bar runs SUM, TGT, 4 divide-by-5
// digit steps, EMA, CMP, then OUT if its ratio saturates or its average is zero, else 12
// restoring divide steps and OUT. Bars are accepted only in IDLE, one at a time.
// Synchronous reset (aresetn low): window_len 32, window and average cleared, no result held.
module windowed_signed_volume_pressure (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wsvp_pkg::WLEN_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wsvp_pkg::PRICE_W-1:0]   s_close_price,
    input  logic [wsvp_pkg::VOL_W-1:0]     s_bar_volume,
    input  logic                           s_restart,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wsvp_pkg::Q_W-1:0]       m_marker_size
);

    // ---- control and series state ----
    wsvp_pkg::state_t                state_reg, state_next;
    logic [wsvp_pkg::WLEN_W-1:0]     win_len_reg, win_len_next;
    logic [wsvp_pkg::PRICE_W-1:0]    prev_close_reg, prev_close_next;
    logic [wsvp_pkg::RING_AW-1:0]    ptr_reg, ptr_next;
    logic [wsvp_pkg::WLEN_W-1:0]     entries_reg, entries_next;
    logic [wsvp_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [wsvp_pkg::EMA_W-1:0]      ema_reg, ema_next;
    logic [1:0]                      bars_reg, bars_next;
    logic                            m_valid_reg, m_valid_next;

    // ---- item payload and shared datapath registers ----
    logic [wsvp_pkg::PRICE_W-1:0]    close_reg, close_next;
    logic [wsvp_pkg::VOL_W-1:0]      vol_reg, vol_next;
    logic                            seed_reg, seed_next;
    logic                            neg_reg, neg_next;
    logic [wsvp_pkg::EMA_W-1:0]      t_reg, t_next;
    logic [wsvp_pkg::WORK_W-1:0]     work_reg, work_next;
    logic [wsvp_pkg::WORK_W-1:0]     dsr_reg, dsr_next;
    logic [2:0]                      rem5_reg, rem5_next;
    logic [wsvp_pkg::Q_W-1:0]        quot_reg, quot_next;
    logic [wsvp_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [wsvp_pkg::Q_W-1:0]        res_reg, res_next;
    logic [wsvp_pkg::Q_W-1:0]        m_data_reg, m_data_next;

    // ---- combinational helpers ----
    wsvp_pkg::ring_req_t             ring_req;
    logic [wsvp_pkg::SV_W-1:0]       old_vol;
    logic [wsvp_pkg::WLEN_W-1:0]     win_eff;
    logic [wsvp_pkg::SV_W-1:0]       sv;
    logic [wsvp_pkg::SUM_W-1:0]      sv_ext;
    logic [wsvp_pkg::SUM_W-1:0]      old_ext;
    logic [wsvp_pkg::EMA_W-1:0]      t_wide;
    logic [wsvp_pkg::DLT_W-1:0]      delta;
    logic [wsvp_pkg::DLT_W-1:0]      delta_mag;
    logic [18:0]                     div5_x;
    logic [37:0]                     div5_prod;
    logic [wsvp_pkg::DIGIT_W-1:0]    div5_q;
    logic [18:0]                     div5_back;
    logic [wsvp_pkg::EMA_W-1:0]      mag_t;
    logic [wsvp_pkg::EMA_W-1:0]      mag_ema;
    logic [wsvp_pkg::WORK_W-1:0]     mag_t_wide;
    logic                            div_ge;
    logic [wsvp_pkg::Q_W-1:0]        quot_shift;

    wsvp_ring u_ring (
        .aclk    (aclk),
        .req     (ring_req),
        .old_vol (old_vol)
    );

    assign win_eff = wsvp_pkg::eff_window(win_len_reg);

    // Signed volume: rose or held counts plus, fell counts minus.
    assign sv = (close_reg >= prev_close_reg) ? {1'b0, vol_reg}
                                              : (33'd0 - {1'b0, vol_reg});
    assign sv_ext  = {{(wsvp_pkg::SUM_W - wsvp_pkg::SV_W){sv[wsvp_pkg::SV_W-1]}}, sv};
    assign old_ext = {{(wsvp_pkg::SUM_W - wsvp_pkg::SV_W){old_vol[wsvp_pkg::SV_W-1]}},
                      old_vol};

    // EMA target: window sum scaled by 2^16. |sum| < 2^40, so no saturation is reachable.
    assign t_wide = {sum_reg[wsvp_pkg::SUM_W-1], sum_reg, {wsvp_pkg::FRAC_W{1'b0}}};
    assign delta  = {t_wide[wsvp_pkg::EMA_W-1], t_wide} - {ema_reg[wsvp_pkg::EMA_W-1], ema_reg};
    assign delta_mag = delta[wsvp_pkg::DLT_W-1] ? (59'd0 - delta) : delta;

    // Divide by 5, one 16-bit digit per cycle: remainder (< 5) prepended to the next digit.
    assign div5_x    = {rem5_reg, work_reg[wsvp_pkg::DIV5_W-1 -: wsvp_pkg::DIGIT_W]};
    assign div5_prod = div5_x * wsvp_pkg::RECIP5;
    assign div5_q    = div5_prod[wsvp_pkg::RECIP_SHIFT +: wsvp_pkg::DIGIT_W];
    assign div5_back = {3'b000, div5_q} + {1'b0, div5_q, 2'b00};

    // Magnitudes for the ratio.
    assign mag_t   = t_reg[wsvp_pkg::EMA_W-1] ? (58'd0 - t_reg) : t_reg;
    assign mag_ema = ema_reg[wsvp_pkg::EMA_W-1] ? (58'd0 - ema_reg) : ema_reg;
    assign mag_t_wide = {{(wsvp_pkg::WORK_W - wsvp_pkg::EMA_W){1'b0}}, mag_t};

    // Restoring divide step: one wide compare and subtract per cycle.
    assign div_ge     = (work_reg >= dsr_reg);
    assign quot_shift = {quot_reg[wsvp_pkg::Q_W-2:0], div_ge};

    always_comb begin
        state_next      = state_reg;
        win_len_next    = win_len_reg;
        prev_close_next = prev_close_reg;
        ptr_next        = ptr_reg;
        entries_next    = entries_reg;
        sum_next        = sum_reg;
        ema_next        = ema_reg;
        bars_next       = bars_reg;
        m_valid_next    = m_valid_reg;
        close_next      = close_reg;
        vol_next        = vol_reg;
        seed_next       = seed_reg;
        neg_next        = neg_reg;
        t_next          = t_reg;
        work_next       = work_reg;
        dsr_next        = dsr_reg;
        rem5_next       = rem5_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        m_data_next     = m_data_reg;

        ring_req.wr_en   = 1'b0;
        ring_req.ptr     = ptr_reg;
        ring_req.win     = win_eff;
        ring_req.wr_data = sv;

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // A window length write empties the window; the average and bar count stay.
        if (cfg_wr_en) begin
            win_len_next = cfg_wr_data;
            ptr_next     = '0;
            entries_next = '0;
            sum_next     = '0;
        end

        case (state_reg)
            wsvp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    close_next = s_close_price;
                    vol_next   = s_bar_volume;
                    // Restart clears the series before this bar is counted.
                    if (s_restart) begin
                        ptr_next     = '0;
                        entries_next = '0;
                        sum_next     = '0;
                        bars_next    = '0;
                    end
                    state_next = wsvp_pkg::ST_SUM;
                end
            end

            wsvp_pkg::ST_SUM: begin
                // First bar of a series has no previous close: no signed volume.
                if (bars_reg != 2'd0) begin
                    ring_req.wr_en = 1'b1;
                    if (entries_reg < win_eff) begin
                        entries_next = entries_reg + 9'd1;
                        sum_next     = sum_reg + sv_ext;
                    end else begin
                        sum_next = sum_reg + sv_ext - old_ext;
                    end
                    ptr_next = ptr_reg + 8'd1;
                end
                prev_close_next = close_reg;
                if (bars_reg != 2'd3) begin
                    bars_next = bars_reg + 2'd1;
                end
                seed_next  = (bars_reg == 2'd2);
                state_next = (bars_reg < 2'd2) ? wsvp_pkg::ST_IDLE : wsvp_pkg::ST_TGT;
            end

            wsvp_pkg::ST_TGT: begin
                t_next = t_wide;
                if (seed_reg) begin
                    // Third bar of a series seeds the average with the target.
                    ema_next   = t_wide;
                    state_next = wsvp_pkg::ST_CMP;
                end else begin
                    // Round half away from zero: (|delta| + 2) / 5 with delta's sign.
                    neg_next  = delta[wsvp_pkg::DLT_W-1];
                    work_next = {{(wsvp_pkg::WORK_W - wsvp_pkg::DIV5_W){1'b0}},
                                 ({5'b00000, delta_mag} + 64'd2)};
                    rem5_next  = '0;
                    cnt_next   = '0;
                    state_next = wsvp_pkg::ST_DIV5;
                end
            end

            wsvp_pkg::ST_DIV5: begin
                work_next = {{(wsvp_pkg::WORK_W - wsvp_pkg::DIV5_W){1'b0}},
                             work_reg[wsvp_pkg::DIV5_W-wsvp_pkg::DIGIT_W-1:0], div5_q};
                rem5_next = div5_x[2:0] - div5_back[2:0];
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'(wsvp_pkg::DIV5_STEPS - 1)) begin
                    state_next = wsvp_pkg::ST_EMA;
                end
            end

            wsvp_pkg::ST_EMA: begin
                ema_next = neg_reg ? (ema_reg - work_reg[wsvp_pkg::EMA_W-1:0])
                                   : (ema_reg + work_reg[wsvp_pkg::EMA_W-1:0]);
                state_next = wsvp_pkg::ST_CMP;
            end

            wsvp_pkg::ST_CMP: begin
                if (ema_reg == '0) begin
                    res_next   = '0;
                    state_next = wsvp_pkg::ST_OUT;
                end else if (mag_t >= mag_ema) begin
                    res_next   = wsvp_pkg::FULL_SCALE;
                    state_next = wsvp_pkg::ST_OUT;
                end else begin
                    // Numerator 2560*|T| = (|T| << 11) + (|T| << 9); quotient fits 12 bits.
                    work_next  = (mag_t_wide << 11) + (mag_t_wide << 9);
                    dsr_next   = {1'b0, mag_ema, 11'd0};
                    quot_next  = '0;
                    cnt_next   = 4'(wsvp_pkg::Q_W - 1);
                    state_next = wsvp_pkg::ST_DIV;
                end
            end

            wsvp_pkg::ST_DIV: begin
                if (div_ge) begin
                    work_next = work_reg - dsr_reg;
                end
                dsr_next  = dsr_reg >> 1;
                quot_next = quot_shift;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    res_next   = quot_shift;
                    state_next = wsvp_pkg::ST_OUT;
                end
            end

            wsvp_pkg::ST_OUT: begin
                // Hold until the output register is free, then hand the item over.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = wsvp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = wsvp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wsvp_pkg::ST_IDLE;
            win_len_reg    <= wsvp_pkg::DEFAULT_WINDOW;
            prev_close_reg <= '0;
            ptr_reg        <= '0;
            entries_reg    <= '0;
            sum_reg        <= '0;
            ema_reg        <= '0;
            bars_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            win_len_reg    <= win_len_next;
            prev_close_reg <= prev_close_next;
            ptr_reg        <= ptr_next;
            entries_reg    <= entries_next;
            sum_reg        <= sum_next;
            ema_reg        <= ema_next;
            bars_reg       <= bars_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload and datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        close_reg  <= close_next;
        vol_reg    <= vol_next;
        seed_reg   <= seed_next;
        neg_reg    <= neg_next;
        t_reg      <= t_next;
        work_reg   <= work_next;
        dsr_reg    <= dsr_next;
        rem5_reg   <= rem5_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready       = (state_reg == wsvp_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_marker_size = m_data_reg;

endmodule
